@@ rtl/epp_pkg.sv @@
// Shared constants, types and register codes for the envelope peak picker.
// Used by epp_div, envelope_peak_picker_core and the testbench; depends on nothing else.
package epp_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int FRAME_LEN   = 32768;
  localparam int HALF_LEN    = FRAME_LEN / 2;

  localparam logic [31:0] SAMPLE_MASK =
      (SAMPLE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << SAMPLE_BITS) - 64'd1);

  // Configuration register indexes
  localparam logic [1:0] CFG_DIRECT_WINDOW      = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD_FRACTION = 2'd1;

  localparam logic [14:0] DW_RESET   = 15'd500;
  localparam logic [15:0] FRAC_RESET = 16'd13107;

  localparam logic [23:0] RATIO_MAX = 24'hFF_FFFF;
  localparam logic [14:0] COUNT_MAX = 15'h7FFF;
  localparam logic [15:0] INDEX_MAX = 16'hFFFF;

  localparam logic KIND_PEAK = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Shared restoring divider sizing
  localparam int DIV_W     = 33;  // divisor and partial remainder
  localparam int DIV_SH_W  = 46;  // dividend bits shifted in, quotient bits out
  localparam int DIV_CNT_W = 6;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_VERTEX = DIV_CNT_W'(46);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_RATIO  = DIV_CNT_W'(24);

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ rtl/epp_div.sv @@
// Bit-serial restoring divider shared by the vertex and ratio divisions.
// One quotient bit per cycle; depends on epp_pkg.
module epp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  epp_pkg::div_ctl_t             ctl,
  input  logic [epp_pkg::DIV_W-1:0]     rem_init,
  input  logic [epp_pkg::DIV_SH_W-1:0]  dividend_lo,
  input  logic [epp_pkg::DIV_W-1:0]     divisor,
  output epp_pkg::div_sts_t             sts,
  output logic [epp_pkg::DIV_SH_W-1:0]  quotient
);
  import epp_pkg::*;

  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_SH_W-1:0]  sh_r, sh_nxt;
  logic [DIV_SH_W-1:0]  quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W:0]       cand;
  logic [DIV_W:0]       diff;
  logic                 ge;

  always_comb begin
    cand     = {rem_r, sh_r[DIV_SH_W-1]};
    diff     = cand - {1'b0, dvs_r};
    ge       = (cand >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    sh_nxt   = sh_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      rem_nxt = rem_init;
      dvs_nxt = divisor;
      sh_nxt  = dividend_lo;
      quo_nxt = '0;
      cnt_nxt = ctl.steps;
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[DIV_W-1:0] : cand[DIV_W-1:0];
      sh_nxt   = {sh_r[DIV_SH_W-2:0], 1'b0};
      quo_nxt  = {quo_r[DIV_SH_W-2:0], ge};
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    sh_r  <= sh_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign quotient = quo_r;

`ifndef SYNTH
  a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> ($past(cnt_r) == DIV_CNT_W'(1) && cnt_r == '0))
    else $error("divider done without finishing its last step");
  a_busy_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.busy && !ctl.start) |=> (cnt_r == $past(cnt_r) - DIV_CNT_W'(1)))
    else $error("divider step count did not advance");
  a_start_loads_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> (cnt_r == $past(ctl.steps) && !sts.done))
    else $error("divider start did not load the step count");
`endif

endmodule

@@ rtl/envelope_peak_picker_core.sv @@
// Envelope peak picker: reference maximum, threshold and parabolic peak refinement.
// Depends on epp_pkg and instantiates the shared divider epp_div.
//
// Samples of a frame arrive one request at a time. A sample that yields no
// peak leaves the core in S_IDLE, or, while the index is inside the reference
// window, passes through S_THR for the threshold multiply. A sample that
// completes a peak holds the input while S_SQ starts the shared bit-serial
// divider on the square for the vertex height (46 steps), S_DIV1 waits for
// its done and forms the numerator, S_NUM checks saturation and starts the
// ratio division (24 steps), S_DIV2 waits for its done, and S_PEAK hands the
// peak to the output register. A saturated ratio skips the second division,
// going from S_NUM straight to S_PEAK. A sample marked frame_end adds S_DONE
// for the done result. Handing a result over waits while the output register
// still holds a stalled one. Output results sit in a single output register,
// so the next sample is taken while a result waits.
module envelope_peak_picker_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // samples
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample,
  input  logic        in_frame_end,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_peak_position,
  output logic [23:0] out_peak_ratio,
  output logic [14:0] out_peak_count,
  output logic        out_kind,
  output logic        out_final_res
);
  import epp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_THR, S_SQ, S_DIV1, S_NUM, S_DIV2, S_PEAK, S_DONE
  } state_t;

  state_t       state_r, state_nxt;
  logic [14:0]  dw_r, dw_nxt;
  logic [15:0]  frac_r, frac_nxt;
  logic [31:0]  win0_r, win0_nxt;
  logic [31:0]  win1_r, win1_nxt;
  logic [31:0]  win2_r, win2_nxt;
  logic [15:0]  index_r, index_nxt;
  logic [31:0]  ref_max_r, ref_max_nxt;
  logic [31:0]  thr_r, thr_nxt;
  logic [14:0]  count_r, count_nxt;
  logic         last_r, last_nxt;
  logic [13:0]  pos_r, pos_nxt;
  logic [32:0]  den_r, den_nxt;
  logic [31:0]  mag_r, mag_nxt;
  logic [48:0]  num_r, num_nxt;
  logic [23:0]  ratio_r, ratio_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [13:0]  out_pos_r, out_pos_nxt;
  logic [23:0]  out_ratio_r, out_ratio_nxt;
  logic [14:0]  out_count_r, out_count_nxt;
  logic         out_kind_r, out_kind_nxt;
  logic         out_final_r, out_final_nxt;

  logic [31:0]  smp;
  logic         acc;
  logic         in_win;
  logic         peak_hit;
  logic [15:0]  k_idx;
  logic [15:0]  pos_full;
  logic [33:0]  den_full;
  logic [47:0]  thr_prod;
  logic [63:0]  sq;
  logic         sat;
  logic         out_free;

  div_ctl_t                div_ctl;
  div_sts_t                div_sts;
  logic [DIV_W-1:0]        div_rem_init;
  logic [DIV_SH_W-1:0]     div_lo;
  logic [DIV_W-1:0]        div_divisor;
  logic [DIV_SH_W-1:0]     div_quo;

  epp_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (div_ctl),
    .rem_init    (div_rem_init),
    .dividend_lo (div_lo),
    .divisor     (div_divisor),
    .sts         (div_sts),
    .quotient    (div_quo)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    smp      = in_sample & SAMPLE_MASK;
    in_win   = (index_r < {1'b0, dw_r});
    k_idx    = index_r - 16'd1;
    // old win2 is the candidate, old win1 its left neighbor, smp its right one
    peak_hit = (index_r >= 16'd2) && (k_idx > {1'b0, dw_r}) &&
               ({1'b0, index_r} < 17'(HALF_LEN)) &&
               (win2_r > win1_r) && (win2_r > smp) && (win2_r > thr_r);
    pos_full = (smp < win1_r) ? (k_idx - 16'd1) : k_idx;
    den_full = {1'b0, win2_r, 1'b0} - {2'b0, win1_r} - {2'b0, smp};
    thr_prod = {16'b0, ref_max_r} * {32'b0, frac_r};
    sq       = {32'b0, mag_r} * {32'b0, mag_r};
    sat      = ({8'b0, num_r[48:24]} >= {1'b0, ref_max_r});
  end

  always_comb begin
    state_nxt     = state_r;
    dw_nxt        = dw_r;
    frac_nxt      = frac_r;
    win0_nxt      = win0_r;
    win1_nxt      = win1_r;
    win2_nxt      = win2_r;
    index_nxt     = index_r;
    ref_max_nxt   = ref_max_r;
    thr_nxt       = thr_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    den_nxt       = den_r;
    mag_nxt       = mag_r;
    num_nxt       = num_r;
    ratio_nxt     = ratio_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pos_nxt   = out_pos_r;
    out_ratio_nxt = out_ratio_r;
    out_count_nxt = out_count_r;
    out_kind_nxt  = out_kind_r;
    out_final_nxt = out_final_r;
    div_ctl       = '{start: 1'b0, steps: DIV_STEPS_VERTEX};
    div_rem_init  = {2'b0, sq[63:33]};
    div_lo        = {sq[32:0], 13'b0};
    div_divisor   = den_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIRECT_WINDOW:      dw_nxt   = cfg_data[14:0];
        CFG_THRESHOLD_FRACTION: frac_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          win0_nxt = win1_r;
          win1_nxt = win2_r;
          win2_nxt = smp;
          last_nxt = in_frame_end;
          if (in_win && smp > ref_max_r) ref_max_nxt = smp;
          if (index_r != INDEX_MAX) index_nxt = index_r + 16'd1;
          if (peak_hit) begin
            if (count_r != COUNT_MAX) count_nxt = count_r + 15'd1;
            pos_nxt = pos_full[13:0];
            den_nxt = den_full[32:0];
            mag_nxt = (smp < win1_r) ? (win1_r - smp) : (smp - win1_r);
          end
          if (in_win)             state_nxt = S_THR;
          else if (peak_hit)      state_nxt = S_SQ;
          else if (in_frame_end)  state_nxt = S_DONE;
          else                    state_nxt = S_IDLE;
        end
      end
      S_THR: begin
        thr_nxt   = thr_prod[47:16];
        state_nxt = last_r ? S_DONE : S_IDLE;
      end
      S_SQ: begin
        // height offset scaled by 2^16: mag^2 * 2^13 / den
        div_ctl   = '{start: 1'b1, steps: DIV_STEPS_VERTEX};
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        if (div_sts.done) begin
          num_nxt   = {1'b0, win1_r, 16'b0} + {3'b0, div_quo};
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        div_rem_init = {8'b0, num_r[48:24]};
        div_lo       = {num_r[23:0], 22'b0};
        div_divisor  = {1'b0, ref_max_r};
        if (sat) begin
          // zero maximum lands here as well
          ratio_nxt = RATIO_MAX;
          state_nxt = S_PEAK;
        end else begin
          div_ctl   = '{start: 1'b1, steps: DIV_STEPS_RATIO};
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_sts.done) begin
          ratio_nxt = div_quo[23:0];
          state_nxt = S_PEAK;
        end
      end
      S_PEAK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_ratio_nxt = ratio_r;
          out_count_nxt = count_r;
          out_kind_nxt  = KIND_PEAK;
          out_final_nxt = !last_r;
          state_nxt     = last_r ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = '0;
          out_ratio_nxt = '0;
          out_count_nxt = count_r;
          out_kind_nxt  = KIND_DONE;
          out_final_nxt = 1'b1;
          // drop the frame state
          win0_nxt      = '0;
          win1_nxt      = '0;
          win2_nxt      = '0;
          index_nxt     = '0;
          ref_max_nxt   = '0;
          thr_nxt       = '0;
          count_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    pos_r       <= pos_nxt;
    den_r       <= den_nxt;
    mag_r       <= mag_nxt;
    num_r       <= num_nxt;
    ratio_r     <= ratio_nxt;
    out_pos_r   <= out_pos_nxt;
    out_ratio_r <= out_ratio_nxt;
    out_count_r <= out_count_nxt;
    out_kind_r  <= out_kind_nxt;
    out_final_r <= out_final_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dw_r        <= DW_RESET;
      frac_r      <= FRAC_RESET;
      win0_r      <= '0;
      win1_r      <= '0;
      win2_r      <= '0;
      index_r     <= '0;
      ref_max_r   <= '0;
      thr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dw_r        <= dw_nxt;
      frac_r      <= frac_nxt;
      win0_r      <= win0_nxt;
      win1_r      <= win1_nxt;
      win2_r      <= win2_nxt;
      index_r     <= index_nxt;
      ref_max_r   <= ref_max_nxt;
      thr_r       <= thr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_peak_position = out_pos_r;
  assign out_peak_ratio    = out_ratio_r;
  assign out_peak_count    = out_count_r;
  assign out_kind          = out_kind_r;
  assign out_final_res     = out_final_r;

`ifndef SYNTH
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, count_r} <= index_r))
    else $error("peak count exceeds sample index");
  a_thr_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    (thr_r <= ref_max_r))
    else $error("threshold above reference maximum");
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider finished outside a divide state");
  a_peak_starts_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && peak_hit) |=> (state_r == S_SQ))
    else $error("detected peak did not start the parabola fit");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (index_r == '0 && count_r == '0))
    else $error("frame state not cleared after done result");
`endif

endmodule

@@ test/tb_envelope_peak_picker_core.sv @@
// Self-checking testbench for envelope_peak_picker_core: directed frames, random frames,
// register changes between phases and output back-pressure.
// Depends on epp_pkg and the envelope_peak_picker_core RTL.
module tb_envelope_peak_picker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import epp_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE      = 100;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [13:0] pos;
    logic [23:0] ratio;
    logic [14:0] cnt;
    logic        kind;
    logic        fin;
  } pick_t;

  typedef struct {
    logic [31:0] s;
    logic        fe;
    bit          typed;
    logic [14:0] cnt;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_sample = '0;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [13:0] out_peak_position;
  logic [23:0] out_peak_ratio;
  logic [14:0] out_peak_count;
  logic        out_kind;
  logic        out_final_res;

  envelope_peak_picker_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_peak_position (out_peak_position),
    .out_peak_ratio    (out_peak_ratio),
    .out_peak_count    (out_peak_count),
    .out_kind          (out_kind),
    .out_final_res     (out_final_res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the picker: registers and frame state
  logic [14:0] win_len   = DW_RESET;
  logic [15:0] frac      = FRAC_RESET;
  logic [31:0] w0 = '0, w1 = '0, w2 = '0;
  logic [15:0] at_index  = '0;
  logic [31:0] level_max = '0;
  logic [31:0] level_gate = '0;
  logic [14:0] found     = '0;

  pick_t results_due [$];
  int    mism = 0;
  int    cycle_cnt = 0;
  int    burst_left = 0;
  int    hold_asks = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  logic [11:0] stall_phase = '0;

  // Vertex height over the reference maximum, Q8.16, saturating
  function automatic logic [23:0] vertex_ratio(input logic [63:0] y0, y1, y2);
    logic [63:0] den8, mag, sq, q, r, h, t;
    den8 = 64'd8 * (64'd2 * y1 - y0 - y2);
    mag  = (y2 < y0) ? y0 - y2 : y2 - y0;
    sq   = mag * mag;
    q    = sq / den8;
    r    = sq % den8;
    h    = y1 + q;
    if (level_max == '0) return RATIO_MAX;
    if (h >= (64'(level_max) << 8)) return RATIO_MAX;
    t = ((h << 16) + ((r << 16) / den8)) / 64'(level_max);
    return (t > 64'(RATIO_MAX)) ? RATIO_MAX : t[23:0];
  endfunction

  function automatic int pick_step(input logic [31:0] raw, input logic fe,
                                   output pick_t res [2]);
    logic [31:0] s;
    int          i, k, n;
    s = raw & SAMPLE_MASK;
    i = int'(at_index);
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (i < int'(win_len)) begin
      if (s > level_max) level_max = s;
      level_gate = 32'((64'(level_max) * 64'(frac)) >> 16);
    end
    w0 = w1;
    w1 = w2;
    w2 = s;
    if (i >= 2) begin
      k = i - 1;
      if (k > int'(win_len) && k + 1 < HALF_LEN && w1 > w0 && w1 > w2 && w1 > level_gate)
      begin
        if (found < COUNT_MAX) found = found + 15'd1;
        res[n].pos   = 14'((w2 < w0) ? k - 1 : k);
        res[n].ratio = vertex_ratio(64'(w0), 64'(w1), 64'(w2));
        res[n].cnt   = found;
        res[n].kind  = KIND_PEAK;
        res[n].fin   = !fe;
        n++;
      end
    end
    if (at_index < INDEX_MAX) at_index = at_index + 16'd1;
    if (fe) begin
      res[n] = '{pos: '0, ratio: '0, cnt: found, kind: KIND_DONE, fin: 1'b1};
      n++;
      w0 = '0;
      w1 = '0;
      w2 = '0;
      at_index = '0;
      level_max = '0;
      level_gate = '0;
      found = '0;
    end
    return n;
  endfunction

  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_DIRECT_WINDOW) win_len = val[14:0];
    else if (idx == CFG_THRESHOLD_FRACTION) frac = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request and hold it until taken; then queue what it should produce
  task automatic push_sample(input logic [31:0] s, input logic fe, input bit typed,
                             input logic [14:0] tcnt);
    pick_t got [2];
    int    n;
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = pick_step(s, fe, got);
    if (typed)
      results_due.push_back('{pos: '0, ratio: '0, cnt: tcnt, kind: KIND_DONE, fin: 1'b1});
    else
      for (int j = 0; j < n; j++) results_due.push_back(got[j]);
  endtask

  // Bursts of requests with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(input int style, input int j);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 7);
      2: return j[0] ? 32'($urandom_range(1000, 1 << 20)) : 32'($urandom_range(0, 999));
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h0;
          1: return 32'h1;
          2: return 32'hFFFF_FFFE;
          3: return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  task automatic run_frames(input int n, input int max_len, input bit leave_open);
    int          left, style;
    logic [31:0] s;
    logic        fe;
    left = 0;
    style = 0;
    for (int j = 0; j < n; j++) begin
      if (left == 0) begin
        left = $urandom_range(1, max_len);
        style = $urandom_range(0, 3);
      end
      s = pick_value(style, j);
      left--;
      fe = (left == 0);
      if (j == n - 1) fe = !leave_open;
      pace();
      push_sample(s, fe, 1'b0, '0);
    end
  endtask

  task automatic phase(input logic [15:0] dw, input logic [15:0] fr, input int n,
                       input int max_len, input bit leave_open);
    settle();
    set_reg(CFG_DIRECT_WINDOW, dw);
    set_reg(CFG_THRESHOLD_FRACTION, fr);
    run_frames(n, max_len, leave_open);
  endtask

  // Receiver: long hold on request, otherwise a stall pattern that changes over time
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      stall_phase <= stall_phase + 12'd1;
      case (stall_phase[9:8])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 99) < 30);
        2'd2: out_stall <= (stall_phase[2:0] < 3'd3);
        default: out_stall <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  // Compare each taken result with the oldest one due
  always @(posedge clk) begin
    pick_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{pos: out_peak_position, ratio: out_peak_ratio, cnt: out_peak_count,
              kind: out_kind, fin: out_final_res};
      if (results_due.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("unexpected result: pos=%0d ratio=%h cnt=%0d kind=%0d fin=%0d",
                   got.pos, got.ratio, got.cnt, got.kind, got.fin);
      end else begin
        want = results_due.pop_front();
        if (got.pos !== want.pos || got.ratio !== want.ratio || got.cnt !== want.cnt ||
            got.kind !== want.kind || got.fin !== want.fin) begin
          mism++;
          if (mism <= 10)
            $display("result mismatch: expected pos=%0d ratio=%h cnt=%0d kind=%0d fin=%0d, %s",
                     want.pos, want.ratio, want.cnt, want.kind, want.fin,
                     $sformatf("got pos=%0d ratio=%h cnt=%0d kind=%0d fin=%0d",
                               got.pos, got.ratio, got.cnt, got.kind, got.fin));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("envelope_peak_picker_core verification failed");
      $finish;
    end
  end

  row_t plan [26];

  initial begin
    plan = '{
      // lone sample closing a frame: done with no peaks
      '{32'd100, 1'b1, 1'b1, 15'd0},
      '{32'd100, 1'b0, 1'b0, 15'd0},
      '{32'd10, 1'b0, 1'b0, 15'd0},
      '{32'd200, 1'b0, 1'b0, 15'd0},
      '{32'd50, 1'b0, 1'b0, 15'd0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 15'd0},
      '{32'd0, 1'b0, 1'b0, 15'd0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 15'd0},
      '{32'hFFFF_FFFE, 1'b0, 1'b0, 15'd0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 15'd0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 15'd0},
      '{32'd0, 1'b0, 1'b0, 15'd0},
      '{32'd40, 1'b0, 1'b0, 15'd0},
      // last local max sits under the threshold
      '{32'd30, 1'b1, 1'b1, 15'd3},
      '{32'd5, 1'b0, 1'b0, 15'd0},
      '{32'd1, 1'b0, 1'b0, 15'd0},
      '{32'd9, 1'b0, 1'b0, 15'd0},
      '{32'd1, 1'b0, 1'b0, 15'd0},
      '{32'd20, 1'b0, 1'b0, 15'd0},
      // peak and done from the same request
      '{32'd3, 1'b1, 1'b0, 15'd0},
      // zero reference maximum
      '{32'd0, 1'b0, 1'b0, 15'd0},
      '{32'd0, 1'b0, 1'b0, 15'd0},
      '{32'd0, 1'b0, 1'b0, 15'd0},
      '{32'd7, 1'b0, 1'b0, 15'd0},
      '{32'd0, 1'b0, 1'b0, 15'd0},
      '{32'd0, 1'b1, 1'b1, 15'd1}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_reg(CFG_DIRECT_WINDOW, 16'd1);
    set_reg(CFG_THRESHOLD_FRACTION, 16'h8000);
    foreach (plan[r]) begin
      pace();
      push_sample(plan[r].s, plan[r].fe, plan[r].typed, plan[r].cnt);
    end

    phase(16'd0, 16'd0, 60, 40, 1'b0);
    phase(16'd2, 16'hFFFF, 80, 40, 1'b0);
    phase(16'd16384, 16'($urandom_range(0, 65535)), 40, 20, 1'b0);
    // leave the frame open so the next register write lands mid-frame
    phase(16'($urandom_range(0, 8)), 16'($urandom_range(0, 65535)), 100, 40, 1'b1);

    settle();
    set_reg(CFG_DIRECT_WINDOW, 16'd5);
    set_reg(CFG_THRESHOLD_FRACTION, FRAC_RESET);
    // hold the output while peaks keep coming, so the input backs up
    hold_asks <= hold_asks + 1;
    for (int j = 0; j < 40; j++) push_sample(pick_value(2, j), 1'b0, 1'b0, '0);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    run_frames(60, 40, 1'b0);

    phase(16'($urandom_range(0, 30)), 16'($urandom_range(0, 65535)), 120, 60, 1'b0);

    settle();
    if (mism == 0) begin
      $display("envelope_peak_picker_core verification clean");
    end else begin
      $display("envelope_peak_picker_core verification failed");
    end
    $finish;
  end

endmodule
